### hdl/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
// No dependencies; used by psu_predict and png_scanline_unfilter_top in hdl/.
package psu_pkg;

    localparam int DEF_MAX_ROW_BYTES = 8192;
    localparam int DEF_MAX_STRIDE    = 8;

    localparam int BYTE_W      = 8;
    localparam int ROW_BYTES_W = 14;
    localparam int STRIDE_W    = 4;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_STRIDE = 1'd1;

    typedef logic [2:0] t_filter;

    localparam t_filter FILT_NONE  = 3'd0;
    localparam t_filter FILT_SUB   = 3'd1;
    localparam t_filter FILT_UP    = 3'd2;
    localparam t_filter FILT_AVG   = 3'd3;
    localparam t_filter FILT_PAETH = 3'd4;

    // Operands handed to the predictor for one data byte.
    typedef struct packed {
        t_filter             filter;
        logic [BYTE_W-1:0]   filtered;
        logic [BYTE_W-1:0]   left;
        logic [BYTE_W-1:0]   above;
        logic [BYTE_W-1:0]   above_left;
    } t_pred_in;

endpackage

### hdl/psu_above_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the previous row.
// Depends on nothing; read data is registered.
module psu_above_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/psu_predict.sv
// Filter predictor and reconstruction adder (None, Sub, Up, Average, Paeth).
// Depends on psu_pkg for the operand struct and filter codes.
module psu_predict (
    input  psu_pkg::t_pred_in            i_op,
    output logic [psu_pkg::BYTE_W-1:0]   o_result
);

    logic signed [9:0] a_s, b_s, c_s;
    logic signed [9:0] pa_d, pb_d, pc_d;
    logic [9:0]        pa, pb, pc;
    logic [8:0]        avg_sum;
    logic [7:0]        paeth_pick;
    logic [7:0]        pred;

    always_comb begin
        a_s  = $signed({2'b00, i_op.left});
        b_s  = $signed({2'b00, i_op.above});
        c_s  = $signed({2'b00, i_op.above_left});
        pa_d = b_s - c_s;
        pb_d = a_s - c_s;
        pc_d = a_s + b_s - (c_s <<< 1);
        pa   = (pa_d < 0) ? 10'(-pa_d) : 10'(pa_d);
        pb   = (pb_d < 0) ? 10'(-pb_d) : 10'(pb_d);
        pc   = (pc_d < 0) ? 10'(-pc_d) : 10'(pc_d);

        // Ties go to left, then above, then above-left.
        if (pa <= pb && pa <= pc) begin
            paeth_pick = i_op.left;
        end else if (pb <= pc) begin
            paeth_pick = i_op.above;
        end else begin
            paeth_pick = i_op.above_left;
        end

        avg_sum = {1'b0, i_op.left} + {1'b0, i_op.above};

        case (i_op.filter)
            psu_pkg::FILT_SUB:   pred = i_op.left;
            psu_pkg::FILT_UP:    pred = i_op.above;
            psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FILT_PAETH: pred = paeth_pick;
            default:             pred = 8'd0;
        endcase

        o_result = i_op.filtered + pred;
    end

endmodule

### hdl/png_scanline_unfilter_top.sv
// Top level of the PNG scanline unfilter: front end, above-row RAM, predictor.
// Depends on psu_pkg, psu_above_ram and psu_predict.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries the inflated PNG
// stream one byte per transaction. The first byte of each row is its filter
// type and produces no output; i_image_start marks the filter byte of an
// image's first row and abandons any partial row. Each following data byte
// yields one output transaction (o_out_valid / i_out_ready) with the
// reconstructed byte and a row_end flag on the row's last byte.
// Configuration (row_bytes, pixel_stride) is written through i_cfg_we while
// the block is idle and applies from the next byte on.
// The above-row RAM read is issued at the edge that accepts a data byte into
// stage one; the predictor loads the output register from stage one when that
// register is free, which raises o_out_valid. Throughput is one byte per cycle
// while i_out_ready stays high, set by the single RAM read and write port pair
// and the one-byte left-neighbour loop through the predictor.
// When the receiver stalls, the output register and the stage behind it fill
// and o_in_ready drops; nothing is lost. Reset (synchronous, i_rst_n low)
// empties the pipeline, expects a filter byte next and treats the next row as
// an image's first row. The RAM needs no clearing pass.
module png_scanline_unfilter_top #(
    parameter int MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_STRIDE    = psu_pkg::DEF_MAX_STRIDE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [psu_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [psu_pkg::BYTE_W-1:0]         i_stream_byte,
    input  logic                               i_image_start,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [psu_pkg::BYTE_W-1:0]         o_pixel_byte,
    output logic                               o_row_end
);

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
    localparam int BW = psu_pkg::BYTE_W;

    // Configuration registers.
    logic [psu_pkg::ROW_BYTES_W-1:0] r_row_bytes;
    logic [psu_pkg::STRIDE_W-1:0]    r_stride;

    // Front-end row state.
    logic [AW-1:0]        r_column;
    psu_pkg::t_filter     r_row_filter;
    logic                 r_await;
    logic                 r_first_row;

    // Stage one: waiting on the RAM read.
    logic                 r_s1_valid;
    logic [BW-1:0]        r_s1_byte;
    psu_pkg::t_filter     r_s1_filter;
    logic                 r_s1_first;
    logic                 r_s1_end;
    logic [AW-1:0]        r_s1_col;

    // Left and above-left histories, newest first.
    logic [BW-1:0]        r_left [MAX_STRIDE];
    logic [BW-1:0]        r_al   [MAX_STRIDE];

    // Output register.
    logic                 r_out_valid;
    logic [BW-1:0]        r_out_byte;
    logic                 r_out_end;

    logic [AW:0]          rb_eff;
    logic [AW:0]          col_next;
    logic [SW-1:0]        sidx;
    logic                 accept;
    logic                 s1_adv;
    logic                 await_eff;
    logic                 is_data;
    logic                 row_done;
    logic [BW-1:0]        ram_rdata;
    logic [BW-1:0]        above;
    logic [BW-1:0]        result;
    psu_pkg::t_pred_in    pred_op;

    always_comb begin
        if (r_row_bytes == '0) begin
            rb_eff = (AW+1)'(1);
        end else if (32'(r_row_bytes) > 32'(MAX_ROW_BYTES)) begin
            rb_eff = (AW+1)'(MAX_ROW_BYTES);
        end else begin
            rb_eff = (AW+1)'(r_row_bytes);
        end

        if (r_stride == '0 || MAX_STRIDE == 1) begin
            sidx = '0;
        end else if (32'(r_stride) > 32'(MAX_STRIDE)) begin
            sidx = SW'(MAX_STRIDE - 1);
        end else begin
            sidx = SW'(r_stride - 1'b1);
        end
    end

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign await_eff  = r_await || i_image_start;
    assign is_data    = accept && !await_eff;
    assign col_next   = {1'b0, r_column} + (AW+1)'(1);
    assign row_done   = col_next >= rb_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= psu_pkg::ROW_BYTES_W'(1);
            r_stride    <= psu_pkg::STRIDE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psu_pkg::REG_ROW_BYTES:
                    r_row_bytes <= i_cfg_data[psu_pkg::ROW_BYTES_W-1:0];
                psu_pkg::REG_PIXEL_STRIDE:
                    r_stride <= i_cfg_data[psu_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: filter bytes are consumed here, data bytes issue a RAM read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_row_filter <= psu_pkg::FILT_NONE;
            r_await      <= 1'b1;
            r_first_row  <= 1'b1;
        end else if (accept) begin
            if (await_eff) begin
                r_row_filter <= (i_stream_byte > BW'(psu_pkg::FILT_PAETH))
                                ? psu_pkg::FILT_NONE : i_stream_byte[2:0];
                r_column     <= '0;
                r_await      <= 1'b0;
                if (i_image_start) begin
                    r_first_row <= 1'b1;
                end
            end else if (row_done) begin
                r_column    <= '0;
                r_await     <= 1'b1;
                r_first_row <= 1'b0;
            end else begin
                r_column <= col_next[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (is_data) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_data) begin
            r_s1_byte   <= i_stream_byte;
            r_s1_filter <= r_row_filter;
            r_s1_first  <= r_first_row;
            r_s1_end    <= row_done;
            r_s1_col    <= r_column;
        end
    end

    // A column is rewritten only after a filter byte has passed, so the
    // read of a column never meets its own pending write; no bypass needed.
    psu_above_ram #(
        .DEPTH (MAX_ROW_BYTES),
        .WIDTH (BW)
    ) u_above_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (result),
        .i_re    (is_data),
        .i_raddr (r_column),
        .o_rdata (ram_rdata)
    );

    assign above = r_s1_first ? '0 : ram_rdata;

    always_comb begin
        pred_op.filter     = r_s1_filter;
        pred_op.filtered   = r_s1_byte;
        pred_op.left       = r_left[sidx];
        pred_op.above      = above;
        pred_op.above_left = r_al[sidx];
    end

    psu_predict u_predict (
        .i_op     (pred_op),
        .o_result (result)
    );

    // A filter byte clears the histories; it wins over a push in the same cycle
    // because the pushed byte belongs to the row that just ended.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && await_eff)) begin
            for (int i = 0; i < MAX_STRIDE; i++) begin
                r_left[i] <= '0;
                r_al[i]   <= '0;
            end
        end else if (s1_adv) begin
            r_left[0] <= result;
            r_al[0]   <= above;
            for (int i = 1; i < MAX_STRIDE; i++) begin
                r_left[i] <= r_left[i-1];
                r_al[i]   <= r_al[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_byte <= result;
            r_out_end  <= r_s1_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_out_byte;
    assign o_row_end    = r_out_end;

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_data && s1_adv) |-> (r_column != r_s1_col))
        else $error("above-row RAM read and write hit the same column");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_col)
                                     && $stable(r_s1_byte)))
        else $error("stalled stage-one item changed");

    a_await_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_column == '0))
        else $error("column not zero while waiting for a filter byte");

    a_full_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_s1_valid) |-> !o_in_ready)
        else $error("input accepted while both stages are blocked");

endmodule

### bench/png_scanline_unfilter_top_tb.sv
// Self-checking testbench for png_scanline_unfilter_top: directed rows, extreme register
// settings and random row streams, checked against a behavioral unfilter.
// Depends on psu_pkg and the RTL in hdl/.
module png_scanline_unfilter_top_tb;

    localparam int ROW_MAX      = psu_pkg::DEF_MAX_ROW_BYTES;
    localparam int STRIDE_MAX   = psu_pkg::DEF_MAX_STRIDE;
    localparam int BYTE_W       = psu_pkg::BYTE_W;
    // A result passes stage one and the output register before it can be taken; spare
    // cycles let the last transactions settle before the registers change.
    localparam int DRAIN_CYCLES = 10;
    // Receiver stalls at 60 percent make idle runs that reach STALL_LIMIT practically
    // impossible, also with the idle cycles that configuration writes and drains add.
    localparam int STALL_LIMIT  = 4000;
    localparam logic [BYTE_W-1:0] FILT_FIRST_UNKNOWN = 8'd5;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              start;
        bit                hold;
    } t_stream_item;

    typedef struct {
        logic [BYTE_W-1:0] pixel;
        logic              row_end;
    } t_pixel;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [psu_pkg::CFG_INDEX_W-1:0] i_cfg_index = psu_pkg::REG_ROW_BYTES;
    logic [psu_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic [BYTE_W-1:0]               i_stream_byte = '0;
    logic                            i_image_start = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [BYTE_W-1:0]               o_pixel_byte;
    logic                            o_row_end;

    png_scanline_unfilter_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_stream_byte(i_stream_byte),
        .i_image_start(i_image_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_byte (o_pixel_byte),
        .o_row_end    (o_row_end)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_stream_item pending_bytes[$];
    t_pixel       pixels_due[$];
    int n_queued = 0;
    int n_accepted = 0;
    int pixels_checked = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phases_run = 0;
    int image_starts = 0;
    int unknown_rows = 0;
    int filter_rows [5] = '{default: 0};

    // Unfilter state, mirrored from the block.
    logic [psu_pkg::ROW_BYTES_W-1:0] cfg_row_bytes = 14'd1;
    logic [psu_pkg::STRIDE_W-1:0]    cfg_stride = 4'd1;
    logic [BYTE_W-1:0]               above_mem [ROW_MAX];
    logic [BYTE_W-1:0]               left_hist [STRIDE_MAX] = '{default: '0};
    logic [BYTE_W-1:0]               diag_hist [STRIDE_MAX] = '{default: '0};
    int                              recon_col = 0;
    psu_pkg::t_filter                recon_filter = psu_pkg::FILT_NONE;
    bit                              recon_want_filter = 1'b1;
    bit                              recon_first_row = 1'b1;

    // Row position as seen by the stimulus generator at enqueue time.
    bit gen_awaiting = 1'b1;
    int gen_col = 0;

    function automatic int eff_row_bytes(input logic [psu_pkg::ROW_BYTES_W-1:0] v);
        if (v == 0) return 1;
        if (v > ROW_MAX) return ROW_MAX;
        return int'(v);
    endfunction

    function automatic int eff_stride(input logic [psu_pkg::STRIDE_W-1:0] v);
        if (v == 0) return 1;
        if (v > STRIDE_MAX) return STRIDE_MAX;
        return int'(v);
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void unfilter_byte(input logic [BYTE_W-1:0] x, input logic start);
        int rb, st, c, left, up, diag, pa, pb, pc;
        logic [BYTE_W-1:0] pred, pix;
        bit last;
        if (start) begin
            recon_first_row = 1'b1;
            recon_want_filter = 1'b1;
            image_starts++;
        end
        if (recon_want_filter) begin
            if (x > psu_pkg::FILT_PAETH) begin
                recon_filter = psu_pkg::FILT_NONE;
                unknown_rows++;
            end else begin
                recon_filter = x[2:0];
                filter_rows[recon_filter]++;
            end
            recon_col = 0;
            left_hist = '{default: '0};
            diag_hist = '{default: '0};
            recon_want_filter = 1'b0;
            return;
        end
        rb = eff_row_bytes(cfg_row_bytes);
        st = eff_stride(cfg_stride);
        c = (recon_col >= ROW_MAX) ? ROW_MAX - 1 : recon_col;
        left = int'(left_hist[st-1]);
        up = recon_first_row ? 0 : int'(above_mem[c]);
        diag = int'(diag_hist[st-1]);
        case (recon_filter)
            psu_pkg::FILT_SUB:   pred = left[7:0];
            psu_pkg::FILT_UP:    pred = up[7:0];
            psu_pkg::FILT_AVG:   pred = 8'((left + up) >> 1);
            psu_pkg::FILT_PAETH: begin
                pa = magnitude(up - diag);
                pb = magnitude(left - diag);
                pc = magnitude(up + left - 2 * diag);
                if (pa <= pb && pa <= pc) pred = left[7:0];
                else if (pb <= pc) pred = up[7:0];
                else pred = diag[7:0];
            end
            default:             pred = '0;
        endcase
        pix = x + pred;
        above_mem[c] = pix;
        for (int i = STRIDE_MAX - 1; i > 0; i--) begin
            left_hist[i] = left_hist[i-1];
            diag_hist[i] = diag_hist[i-1];
        end
        left_hist[0] = pix;
        diag_hist[0] = up[7:0];
        last = (c + 1 >= rb);
        if (last) begin
            recon_col = 0;
            recon_want_filter = 1'b1;
            recon_first_row = 1'b0;
        end else begin
            recon_col = c + 1;
        end
        pixels_due.push_back('{pix, last});
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        error_count++;
    endtask

    // Driver: presents queued bytes and updates the expected pixels on each transaction.
    always @(posedge i_clk) begin
        t_stream_item nxt;
        bit took;
        took = i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (took) begin
                unfilter_byte(i_stream_byte, i_image_start);
                n_accepted++;
            end
            if (!i_in_valid || took) begin
                if (pending_bytes.size() != 0
                        && !(pending_bytes[0].hold && pixels_due.size() != 0)
                        && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    i_stream_byte <= nxt.value;
                    i_image_start <= nxt.start;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each output transaction with the oldest expected pixel.
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel %02h", o_pixel_byte));
                end else begin
                    want = pixels_due.pop_front();
                    if (o_pixel_byte !== want.pixel)
                        report_mismatch($sformatf("pixel %02h, expected %02h",
                                                  o_pixel_byte, want.pixel));
                    if (o_row_end !== want.row_end)
                        report_mismatch($sformatf("row_end %b, expected %b for pixel %02h",
                                                  o_row_end, want.row_end, want.pixel));
                    pixels_checked++;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(input logic [psu_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [psu_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == psu_pkg::REG_ROW_BYTES) cfg_row_bytes = data;
        else cfg_stride = data[psu_pkg::STRIDE_W-1:0];
    endtask

    function automatic void push_item(input logic [BYTE_W-1:0] b, input logic start,
                                      input bit hold);
        pending_bytes.push_back('{b, start, hold});
        n_queued++;
        if (start) gen_awaiting = 1'b1;
        if (gen_awaiting) begin
            gen_awaiting = 1'b0;
            gen_col = 0;
        end else if (gen_col + 1 >= eff_row_bytes(cfg_row_bytes)) begin
            gen_awaiting = 1'b1;
            gen_col = 0;
        end else begin
            gen_col++;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pick_data_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_filter_byte();
        if ($urandom_range(99) < 85) return 8'($urandom_range(psu_pkg::FILT_PAETH));
        return 8'($urandom_range(255));
    endfunction

    // Well-formed rows with random content, some rows cut short by a new image.
    // A phase that opens a new image first never reads an above entry left unwritten.
    function automatic void random_items(input int n_items, input bit opening);
        bit hold;
        for (int k = 0; k < n_items; k++) begin
            hold = ($urandom_range(99) < 2);
            if (k == 0 && opening)
                push_item(pick_filter_byte(), 1'b1, hold);
            else if (!gen_awaiting && $urandom_range(99) < 4)
                push_item(pick_filter_byte(), 1'b1, hold);
            else if (gen_awaiting)
                push_item(pick_filter_byte(), $urandom_range(99) < 8, hold);
            else
                push_item(pick_data_byte(), 1'b0, hold);
        end
    endfunction

    task automatic settle();
        while (n_accepted != n_queued || pixels_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        phases_run++;
    endtask

    task automatic random_phase(input int n_items);
        int old_rb;
        logic [psu_pkg::ROW_BYTES_W-1:0] rb;
        old_rb = eff_row_bytes(cfg_row_bytes);
        case ($urandom_range(9))
            0:       rb = '0;
            1:       rb = 14'd1;
            2:       rb = 14'($urandom_range(90, 40));
            default: rb = 14'($urandom_range(24, 2));
        endcase
        write_reg(psu_pkg::REG_ROW_BYTES, rb);
        write_reg(psu_pkg::REG_PIXEL_STRIDE,
                  {10'($urandom_range(1023)), 4'($urandom_range(15))});
        // A longer row would reach above entries the current image never wrote.
        random_items(n_items, eff_row_bytes(cfg_row_bytes) > old_rb);
        settle();
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct = 60;

        write_reg(psu_pkg::REG_ROW_BYTES, 14'd2);
        write_reg(psu_pkg::REG_PIXEL_STRIDE, 14'd1);
        push_item(8'(psu_pkg::FILT_NONE), 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0); push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'(psu_pkg::FILT_SUB), 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0); push_item(8'h01, 1'b0, 1'b0);
        push_item(8'(psu_pkg::FILT_UP), 1'b0, 1'b0);
        push_item(8'h80, 1'b0, 1'b0); push_item(8'h80, 1'b0, 1'b0);
        push_item(8'(psu_pkg::FILT_AVG), 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0); push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'(psu_pkg::FILT_PAETH), 1'b0, 1'b0);
        push_item(8'h10, 1'b0, 1'b0); push_item(8'hF0, 1'b0, 1'b0);
        push_item(FILT_FIRST_UNKNOWN, 1'b0, 1'b0);
        push_item(8'h55, 1'b0, 1'b0); push_item(8'hAA, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h01, 1'b0, 1'b0); push_item(8'h02, 1'b0, 1'b0);
        // A new image abandons the row after one byte; the sender waits for the pipe to empty.
        push_item(8'(psu_pkg::FILT_PAETH), 1'b0, 1'b0); push_item(8'h33, 1'b0, 1'b0);
        push_item(8'(psu_pkg::FILT_SUB), 1'b1, 1'b1);
        push_item(8'h44, 1'b0, 1'b0); push_item(8'h99, 1'b0, 1'b0);
        settle();

        // Zero row length and zero stride both act as one.
        write_reg(psu_pkg::REG_ROW_BYTES, '0);
        write_reg(psu_pkg::REG_PIXEL_STRIDE, '0);
        push_item(8'(psu_pkg::FILT_SUB), 1'b1, 1'b0);   push_item(8'h7F, 1'b0, 1'b0);
        push_item(8'(psu_pkg::FILT_UP), 1'b0, 1'b0);    push_item(8'h01, 1'b0, 1'b0);
        push_item(8'(psu_pkg::FILT_AVG), 1'b0, 1'b0);   push_item(8'hFE, 1'b0, 1'b0);
        push_item(8'(psu_pkg::FILT_PAETH), 1'b0, 1'b0); push_item(8'h80, 1'b0, 1'b0);
        settle();

        for (int seg = 0; seg < 3; seg++) begin
            send_idle_pct = (seg == 0) ? 33 : (seg == 1) ? 60 : 0;
            recv_idle_pct = (seg == 0) ? 60 : (seg == 1) ? 33 : 0;
            if (seg == 1) begin
                // Both registers saturate: part of a row at the largest length, which a
                // shorter row length cuts off on its next byte; short rows then read it back.
                write_reg(psu_pkg::REG_ROW_BYTES, 14'h3FFF);
                write_reg(psu_pkg::REG_PIXEL_STRIDE, 14'h3FFF);
                push_item(8'(psu_pkg::FILT_PAETH), 1'b1, 1'b0);
                for (int k = 0; k < 40; k++)
                    push_item(pick_data_byte(), 1'b0, 1'b0);
                settle();
                write_reg(psu_pkg::REG_ROW_BYTES, 14'd5);
                write_reg(psu_pkg::REG_PIXEL_STRIDE, 14'd8);
                random_items(25, 1'b0);
                settle();
            end
            repeat (6) random_phase(20);
        end

        $display("Covered %0d stream bytes, %0d pixels checked, %0d image starts, %0d settings.",
                 n_accepted, pixels_checked, image_starts, phases_run);
        $display("Rows by filter: none %0d, sub %0d, up %0d, average %0d, paeth %0d, unknown %0d.",
                 filter_rows[psu_pkg::FILT_NONE], filter_rows[psu_pkg::FILT_SUB],
                 filter_rows[psu_pkg::FILT_UP], filter_rows[psu_pkg::FILT_AVG],
                 filter_rows[psu_pkg::FILT_PAETH], unknown_rows);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hdl/psu_pkg.sv
hdl/psu_above_ram.sv
hdl/psu_predict.sv
hdl/png_scanline_unfilter_top.sv
bench/png_scanline_unfilter_top_tb.sv
